// ===== design/ksm_pkg.sv =====
// ksm_pkg: shared constants, payload types and ordering function for the
// k-way sorted stream merge; no dependencies
`timescale 1ns / 1ps

package ksm_pkg;

  localparam int NUM_SOURCES = 8;
  localparam int SRC_W       = 3;
  localparam int VAL_W       = 64;
  localparam int IDX_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int CNT_W       = $clog2(NUM_SOURCES + 1);

  localparam logic OP_FILL = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [SRC_W-1:0] source;
    logic [VAL_W-1:0] head_value;
    logic             present;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] merged_value;
    logic [SRC_W-1:0] from_source;
    logic             valid_res;
  } out_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [SRC_W-1:0] source;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

  // true when a orders before b by value, then by source
  function automatic logic entry_before(entry_t a, entry_t b);
    logic lt;
    lt = (a.value < b.value) || ((a.value == b.value) && (a.source < b.source));
    return lt;
  endfunction

endpackage

// ===== design/ksm_in_if.sv =====
// ksm_in_if: valid/ready channel carrying fill and take items
// depends on ksm_pkg
`timescale 1ns / 1ps

interface ksm_in_if
  import ksm_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/ksm_out_if.sv =====
// ksm_out_if: valid/ready channel carrying merge results
// depends on ksm_pkg
`timescale 1ns / 1ps

interface ksm_out_if
  import ksm_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/kway_sorted_stream_merge.sv =====
// kway_sorted_stream_merge: top level, min-selection merge over an entry memory
// fill: written straight into the memory if present, source valid and not full; no result
// take: scan reads one entry per cycle from the memory port, then once the output is free
//   the last entry fills the hole and the result is registered; empty take gives all zero
// one item in flight at a time; the result register frees the input side
// reset clears the entry count, sequencer and result valid; memory is not cleared
`timescale 1ns / 1ps

module kway_sorted_stream_merge
  import ksm_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  ksm_in_if.sink    in_i,
  ksm_out_if.source out_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_MOVE  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  entry_t           best_q, best_d;
  logic             first_q, first_d;
  out_item_t        res_q, res_d;
  logic             res_valid_q, res_valid_d;

  ram_wr_t          wr;
  ram_rd_t          rd;
  entry_t           rdata;

  logic             in_xfer;
  logic             out_free;
  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W-1:0] scan_dec;
  logic             fill_ok;

  ksm_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_free    = !res_valid_q || out_o.ready;
  assign out_o.valid = res_valid_q;
  assign out_o.data  = res_q;

  assign cnt_dec  = count_q - CNT_W'(1);
  assign scan_dec = scan_q - CNT_W'(1);
  assign fill_ok  = in_i.data.present
                    && ({1'b0, in_i.data.source} < (SRC_W + 1)'(NUM_SOURCES))
                    && (count_q < CNT_W'(NUM_SOURCES));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    first_d     = first_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    wr          = '0;
    rd          = '0;

    if (res_valid_q && out_o.ready) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_i.data.operation == OP_FILL) begin
            if (fill_ok) begin
              wr.en   = 1'b1;
              wr.addr = count_q[IDX_W-1:0];
              wr.data = '{value: in_i.data.head_value, source: in_i.data.source};
              count_d = count_q + CNT_W'(1);
            end
          end else if (count_q == '0) begin
            state_d = ST_EMPTY;
          end else begin
            rd.en   = 1'b1;
            rd.addr = '0;
            scan_d  = CNT_W'(1);
            first_d = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // rdata holds the entry at scan_q - 1
        first_d = 1'b0;
        if (first_q || entry_before(rdata, best_q)) begin
          best_d     = rdata;
          best_idx_d = scan_dec[IDX_W-1:0];
        end
        rd.en = 1'b1;
        if (scan_q < count_q) begin
          rd.addr = scan_q[IDX_W-1:0];
          scan_d  = scan_q + CNT_W'(1);
        end else begin
          // fetch the last entry to fill the hole
          rd.addr = cnt_dec[IDX_W-1:0];
          state_d = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (out_free) begin
          wr.en       = 1'b1;
          wr.addr     = best_idx_q;
          wr.data     = rdata;
          count_d     = cnt_dec;
          res_d       = '{merged_value: best_q.value, from_source: best_q.source,
                          valid_res: 1'b1};
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          res_d       = '0;
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      first_q     <= 1'b0;
      scan_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      first_q     <= first_d;
      scan_q      <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(NUM_SOURCES))
    else $error("entry count out of range");

  a_empty_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.data.operation == OP_TAKE && count_q == '0) |=> state_q == ST_EMPTY)
    else $error("take on empty store not flagged");

  a_remove_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE && out_free) |=> count_q == $past(cnt_dec))
    else $error("take did not remove exactly one entry");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.valid_res) |-> (res_q.merged_value == '0 && res_q.from_source == '0))
    else $error("end-of-stream result carries data");

endmodule

// ===== design/ksm_store.sv =====
// ksm_store: entry memory, one write port and one read port with
// registered read data; depends on ksm_pkg
`timescale 1ns / 1ps

module ksm_store
  import ksm_pkg::*;
(
  input  logic    clk_i,
  input  ram_wr_t wr_i,
  input  ram_rd_t rd_i,
  output entry_t  rdata_o
);

  entry_t mem [NUM_SOURCES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
